@@ rtl/full_cross_correlator_defines.svh @@
// Assertion macros for the correlator RTL.
`ifndef FULL_CROSS_CORRELATOR_DEFINES_SVH
`define FULL_CROSS_CORRELATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fcc_pkg.sv @@
// Types, widths and codes shared by the correlator modules.
package fcc_pkg;

    localparam int TEMPLATE_DEPTH = 64;
    localparam int SAMPLE_W       = 16;
    localparam int PROD_W         = 2 * SAMPLE_W;
    localparam int CORR_W         = 48;
    localparam int LEN_CFG_W      = 7;
    localparam int TIDX_W         = 6;
    localparam int LEN_W          = $clog2(TEMPLATE_DEPTH + 1);
    localparam int CELL_IDX_W     = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;

    localparam logic FUNC_TEMPLATE = 1'b0;
    localparam logic FUNC_SAMPLE   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [CORR_W-1:0]   t_corr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_REPLAY
    } t_state;

    // What enters the head of the chain on a step
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_ZERO,
        SRC_TAIL
    } t_src;

    typedef struct packed {
        logic step;
        logic clr_sum;
        logic clr_hist;
        logic tmpl_we;
        t_src src;
    } t_chain_ctl;

endpackage

@@ rtl/fcc_if.sv @@
// Valid/ready channel interfaces for samples in and correlation results out.
interface fcc_in_if;
    import fcc_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    t_sample             sample;
    logic [TIDX_W-1:0]   template_index;
    logic                last_sample;

    modport source (output valid, func, sample, template_index, last_sample, input ready);
    modport sink   (input valid, func, sample, template_index, last_sample, output ready);
endinterface

interface fcc_out_if;
    import fcc_pkg::*;

    logic  valid;
    logic  ready;
    t_corr correlation;
    logic  last_result;

    modport source (output valid, correlation, last_result, input ready);
    modport sink   (input valid, correlation, last_result, output ready);
endinterface

@@ rtl/fcc_cell.sv @@
// One correlator cell: template tap, history tap and transposed partial sum.
module fcc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcc_pkg::t_chain_ctl i_ctl,
    input  logic                i_tmpl_we,
    input  fcc_pkg::t_sample    i_x,
    input  fcc_pkg::t_sample    i_hist,
    input  fcc_pkg::t_corr      i_sum,
    output fcc_pkg::t_sample    o_hist,
    output fcc_pkg::t_corr      o_sum
);
    import fcc_pkg::*;

    t_sample                    r_tmpl;
    t_sample                    r_hist;
    t_corr                      r_sum;
    logic signed [PROD_W-1:0]   w_prod;
    t_corr                      n_sum;

    assign w_prod = i_x * r_tmpl;
    assign n_sum  = i_sum + CORR_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (i_tmpl_we) begin
            r_tmpl <= i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_hist) begin
            r_hist <= '0;
        end else if (i_ctl.step) begin
            r_hist <= i_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_sum) begin
            r_sum <= '0;
        end else if (i_ctl.step) begin
            r_sum <= n_sum;
        end
    end

    assign o_hist = r_hist;
    assign o_sum  = r_sum;

endmodule

@@ rtl/fcc_ctrl.sv @@
// Sequencer: input handshake, flush and replay counts, result register.
`include "full_cross_correlator_defines.svh"

module fcc_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fcc_in_if.sink                              i_x_if,
    fcc_out_if.source                           o_res_if,
    input  logic                                i_cfg_we,
    input  logic [fcc_pkg::LEN_CFG_W-1:0]       i_cfg_data,
    input  fcc_pkg::t_corr                      i_tail_sum,
    output fcc_pkg::t_chain_ctl                 o_ctl,
    output logic [fcc_pkg::CELL_IDX_W-1:0]      o_sel
);
    import fcc_pkg::*;

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_cnt, n_cnt;
    logic                   r_dirty, n_dirty;
    logic                   r_pend, n_pend;
    logic                   r_pend_last, n_pend_last;
    logic [LEN_CFG_W-1:0]   r_len;
    logic                   r_out_valid;
    t_corr                  r_out_corr;
    logic                   r_out_last;

    logic [LEN_W-1:0]       w_ny;
    logic                   w_emit;
    logic                   w_can_step;
    logic                   w_acc;
    logic                   w_idx_ok;

    always_comb begin
        if (r_len == '0) begin
            w_ny = LEN_W'(1);
        end else if (r_len > LEN_CFG_W'(TEMPLATE_DEPTH)) begin
            w_ny = LEN_W'(TEMPLATE_DEPTH);
        end else begin
            w_ny = LEN_W'(r_len);
        end
    end

    assign o_sel      = CELL_IDX_W'(w_ny - LEN_W'(1));
    assign w_emit     = r_pend && (!r_out_valid || o_res_if.ready);
    assign w_can_step = !r_pend || w_emit;
    assign w_idx_ok   = (TIDX_W+1)'(i_x_if.template_index) < (TIDX_W+1)'(TEMPLATE_DEPTH);

    assign i_x_if.ready = (r_state == ST_IDLE) && w_can_step;
    assign w_acc        = i_x_if.valid && i_x_if.ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dirty     = r_dirty;
        n_pend      = r_pend && !w_emit;
        n_pend_last = r_pend_last;
        o_ctl       = '0;
        o_ctl.src   = SRC_INPUT;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_x_if.func == FUNC_SAMPLE) begin
                        o_ctl.step  = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_last = i_x_if.last_sample && (w_ny == LEN_W'(1));
                        n_dirty     = 1'b1;
                        if (i_x_if.last_sample) begin
                            n_state = ST_FLUSH;
                            n_cnt   = w_ny - LEN_W'(1);
                        end
                    end else begin
                        o_ctl.tmpl_we = w_idx_ok;
                        // rebuild the partial sums against the new template
                        if (r_dirty) begin
                            o_ctl.clr_sum = 1'b1;
                            n_state       = ST_REPLAY;
                            n_cnt         = LEN_W'(TEMPLATE_DEPTH);
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (w_can_step) begin
                    if (r_cnt != '0) begin
                        o_ctl.step  = 1'b1;
                        o_ctl.src   = SRC_ZERO;
                        n_pend      = 1'b1;
                        n_pend_last = (r_cnt == LEN_W'(1));
                        n_cnt       = r_cnt - LEN_W'(1);
                    end else begin
                        o_ctl.clr_sum  = 1'b1;
                        o_ctl.clr_hist = 1'b1;
                        n_dirty        = 1'b0;
                        n_state        = ST_IDLE;
                    end
                end
            end
            ST_REPLAY: begin
                // rotate the history once round, oldest sample first
                o_ctl.step = 1'b1;
                o_ctl.src  = SRC_TAIL;
                n_cnt      = r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_dirty     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_len       <= LEN_CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dirty     <= n_dirty;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_corr <= i_tail_sum;
            r_out_last <= r_pend_last;
        end
    end

    assign o_res_if.valid       = r_out_valid;
    assign o_res_if.correlation = r_out_corr;
    assign o_res_if.last_result = r_out_last;

    `FCC_ASSERT_NOW(a_step_no_overwrite, i_clk, i_rst_n, o_ctl.step && r_state != ST_REPLAY, !r_pend || w_emit, "chain stepped over an unsent result")
    `FCC_ASSERT_NOW(a_replay_no_pend, i_clk, i_rst_n, r_state == ST_REPLAY, !r_pend, "result pending during replay")
    `FCC_ASSERT_NOW(a_last_at_flush_end, i_clk, i_rst_n, w_emit && r_pend_last, r_state == ST_FLUSH && r_cnt == '0, "final lag sent outside flush end")
    `FCC_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, o_ctl.clr_hist, r_state == ST_IDLE && !r_dirty, "flush end did not return to idle")

endmodule

@@ rtl/full_cross_correlator.sv @@
// A sample's lag is registered in the cell sums at its transfer and moves to the result
// register once that is free. One x sample or template write per cycle, while idle and
// not held by an unsent result; a last sample adds ny-1 flush lags and a clearing step.
// A template write after samples have entered the history makes the cell row replay the
// history through the new template. Reset (synchronous, active low): history and sums
// zero, template length 1, template taps undefined until written.
module full_cross_correlator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fcc_in_if.sink                          i_x_if,
    fcc_out_if.source                       o_res_if,
    input  logic                            i_cfg_we,
    input  logic [fcc_pkg::LEN_CFG_W-1:0]   i_cfg_data
);
    import fcc_pkg::*;

    t_chain_ctl                 w_ctl;
    logic [CELL_IDX_W-1:0]      w_sel;
    t_sample                    w_x;
    t_sample                    w_cell_hist [0:TEMPLATE_DEPTH-1];
    t_corr                      w_cell_sum  [0:TEMPLATE_DEPTH-1];

    always_comb begin
        case (w_ctl.src)
            SRC_INPUT: w_x = i_x_if.sample;
            SRC_ZERO:  w_x = '0;
            SRC_TAIL:  w_x = w_cell_hist[TEMPLATE_DEPTH-1];
            default:   w_x = '0;
        endcase
    end

    fcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_x_if     (i_x_if),
        .o_res_if   (o_res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_tail_sum (w_cell_sum[w_sel]),
        .o_ctl      (w_ctl),
        .o_sel      (w_sel)
    );

    for (genvar g = 0; g < TEMPLATE_DEPTH; g++) begin : g_cell
        t_sample w_hist_in;
        t_corr   w_sum_in;
        logic    w_we;

        if (g == 0) begin : g_head
            assign w_hist_in = w_x;
            assign w_sum_in  = '0;
        end else begin : g_body
            assign w_hist_in = w_cell_hist[g-1];
            assign w_sum_in  = w_cell_sum[g-1];
        end

        assign w_we = w_ctl.tmpl_we && (i_x_if.template_index == TIDX_W'(g));

        fcc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_tmpl_we (w_we),
            .i_x       (w_x),
            .i_hist    (w_hist_in),
            .i_sum     (w_sum_in),
            .o_hist    (w_cell_hist[g]),
            .o_sum     (w_cell_sum[g])
        );
    end

endmodule
